// ===== sv/nrfc_pkg.sv =====
// nrfc_pkg: shared types, constants and the ack table for the response frame checker
// no dependencies; used by nrfc_datapath, nrfc_ctrl, the top level and the bench
`default_nettype none

package nrfc_pkg;

	localparam int CAPTURE_DEPTH = 32;
	localparam int ACK_LEN       = 6;
	localparam int HDR_MIN_POS   = ACK_LEN + 2;
	localparam int FRAME_EXTRA   = 7;
	localparam int PARAM_OFFSET  = 7;
	localparam int MAX_PARAMS    = 17;

	localparam logic [7:0] TFI_TO_HOST = 8'hD5;
	localparam logic [7:0] HDR_END     = 8'hFF;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_END   = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_SHORT     = 4'd1,
		ST_BAD_ACK   = 4'd2,
		ST_NO_HDR    = 4'd3,
		ST_LCS       = 4'd4,
		ST_LEN_SMALL = 4'd5,
		ST_TRUNC     = 4'd6,
		ST_TFI       = 4'd7,
		ST_CMD       = 4'd8,
		ST_DCS       = 4'd9,
		ST_POSTAMBLE = 4'd10
	} status_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
		logic [7:0] expected_cmd;
		logic [7:0] param_limit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] param_byte;
		logic       has_data;
		logic [3:0] status;
		logic       last;
		logic [4:0] param_count;
	} out_item_t;

	typedef enum logic [1:0] {
		PTR_HOLD  = 2'd0,
		PTR_INC   = 2'd1,
		PTR_ZERO  = 2'd2,
		PTR_FIRST = 2'd3
	} ptr_op_t;

	typedef struct packed {
		logic    latch_start;
		logic    capture_wr;
		ptr_op_t ptr_op;
		logic    shift_win;
		logic    save_start;
		logic    load_len;
		logic    load_rem;
		logic    rem_dec;
		logic    sum_first;
		logic    sum_add;
		logic    load_k;
		logic    err_load;
		status_t err_code;
		logic    out_err;
		logic    out_data;
	} ctrl_cmd_t;

	typedef struct packed {
		logic short_cap;
		logic ack_ok;
		logic ack_last;
		logic ptr_end;
		logic hdr_hit;
		logic hdr_room;
		logic lcs_ok;
		logic len_ok;
		logic frame_room;
		logic tfi_ok;
		logic rsp_ok;
		logic len_two;
		logic rem_one;
		logic dcs_ok;
		logic post_ok;
		logic k_zero;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [7:0] ack_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd2, 3'd4: b = 8'hFF;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== sv/nrfc_chan_if.sv =====
// nrfc_chan_if: valid/ready channel carrying one payload per transfer
// payload type given at instantiation, usually from nrfc_pkg
`default_nettype none

interface nrfc_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/nrfc_ram.sv =====
// nrfc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module nrfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/nrfc_datapath.sv =====
// nrfc_datapath: capture store, byte pointer, frame field registers and result register
// depends on nrfc_pkg and nrfc_ram
`default_nettype none

module nrfc_datapath #(
	parameter int CAPTURE_DEPTH = nrfc_pkg::CAPTURE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nrfc_pkg::ctrl_cmd_t cmd,
	input  wire nrfc_pkg::in_item_t  in_data,
	output      nrfc_pkg::dp_stat_t  stat,
	input  wire logic                out_ready,
	output      logic                out_valid,
	output      nrfc_pkg::out_item_t out_data
);

	localparam int AW = $clog2(CAPTURE_DEPTH);
	localparam int CW = $clog2(CAPTURE_DEPTH + 1);
	localparam int PW = ((CW > 8) ? CW : 8) + 2;

	logic [CW-1:0]      n_q;
	logic [7:0]         cmd_q;
	logic [7:0]         limit_q;
	logic [PW-1:0]      ptr_q;
	logic [PW-1:0]      ptr_d;
	logic [PW-1:0]      start_q;
	logic [PW-1:0]      n_ext;
	logic [7:0]         w0_q;
	logic [7:0]         w1_q;
	logic [7:0]         len_q;
	logic [7:0]         rem_q;
	logic [7:0]         sum_q;
	logic [4:0]         k_q;
	logic [4:0]         idx_q;
	nrfc_pkg::status_t  err_q;
	logic [7:0]         rd_data;
	logic               wr_en;
	logic [7:0]         lenm2;
	logic [7:0]         lim_min;
	logic [4:0]         k_calc;
	nrfc_pkg::out_item_t out_q;
	logic               out_valid_q;

	assign wr_en = cmd.capture_wr && (n_q < CW'(CAPTURE_DEPTH));
	assign n_ext = PW'(n_q);

	always_comb begin
		case (cmd.ptr_op)
			nrfc_pkg::PTR_INC:   ptr_d = ptr_q + PW'(1);
			nrfc_pkg::PTR_ZERO:  ptr_d = '0;
			nrfc_pkg::PTR_FIRST: ptr_d = start_q + PW'(nrfc_pkg::PARAM_OFFSET);
			default:             ptr_d = ptr_q;
		endcase
	end

	nrfc_ram #(
		.WIDTH(8),
		.DEPTH(CAPTURE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(n_q[AW-1:0]),
		.wdata(in_data.rx_byte),
		.raddr(ptr_d[AW-1:0]),
		.rdata(rd_data)
	);

	assign lenm2   = len_q - 8'd2;
	assign lim_min = (lenm2 < limit_q) ? lenm2 : limit_q;
	assign k_calc  = (lim_min > 8'(nrfc_pkg::MAX_PARAMS)) ? 5'(nrfc_pkg::MAX_PARAMS)
		: lim_min[4:0];

	always_comb begin
		stat.short_cap  = n_q < CW'(nrfc_pkg::ACK_LEN);
		stat.ack_ok     = rd_data == nrfc_pkg::ack_byte(ptr_q[2:0]);
		stat.ack_last   = ptr_q == PW'(nrfc_pkg::ACK_LEN - 1);
		stat.ptr_end    = ptr_q >= n_ext;
		stat.hdr_hit    = (ptr_q >= PW'(nrfc_pkg::HDR_MIN_POS)) && (w1_q == nrfc_pkg::BYTE_ZERO)
			&& (w0_q == nrfc_pkg::BYTE_ZERO) && (rd_data == nrfc_pkg::HDR_END);
		stat.hdr_room   = (ptr_q + PW'(3)) <= n_ext;
		stat.lcs_ok     = 8'(len_q + rd_data) == 8'd0;
		stat.len_ok     = len_q >= 8'd2;
		stat.frame_room = (start_q + PW'(len_q) + PW'(nrfc_pkg::FRAME_EXTRA)) <= n_ext;
		stat.tfi_ok     = rd_data == nrfc_pkg::TFI_TO_HOST;
		stat.rsp_ok     = rd_data == 8'(cmd_q + 8'd1);
		stat.len_two    = len_q == 8'd2;
		stat.rem_one    = rem_q == 8'd1;
		stat.dcs_ok     = 8'(sum_q + rd_data) == 8'd0;
		stat.post_ok    = rd_data == nrfc_pkg::BYTE_ZERO;
		stat.k_zero     = k_calc == 5'd0;
		stat.emit_last  = 5'(idx_q + 5'd1) == k_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			cmd_q       <= '0;
			limit_q     <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			idx_q       <= '0;
			err_q       <= nrfc_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q <= ptr_d;
			if (cmd.latch_start) begin
				n_q     <= '0;
				cmd_q   <= in_data.expected_cmd;
				limit_q <= in_data.param_limit;
			end else if (wr_en) begin
				n_q <= n_q + CW'(1);
			end
			if (cmd.load_k) begin
				k_q   <= k_calc;
				idx_q <= '0;
			end else if (cmd.out_data) begin
				idx_q <= idx_q + 5'd1;
			end
			if (cmd.err_load) begin
				err_q <= cmd.err_code;
			end
			if (cmd.out_err || cmd.out_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_win) begin
			w1_q <= w0_q;
			w0_q <= rd_data;
		end
		if (cmd.save_start) begin
			start_q <= ptr_q - PW'(2);
		end
		if (cmd.load_len) begin
			len_q <= rd_data;
		end
		if (cmd.load_rem) begin
			rem_q <= lenm2;
		end else if (cmd.rem_dec) begin
			rem_q <= rem_q - 8'd1;
		end
		if (cmd.sum_first) begin
			sum_q <= rd_data;
		end else if (cmd.sum_add) begin
			sum_q <= 8'(sum_q + rd_data);
		end
		if (cmd.out_err) begin
			out_q.param_byte  <= nrfc_pkg::BYTE_ZERO;
			out_q.has_data    <= 1'b0;
			out_q.status      <= err_q;
			out_q.last        <= 1'b1;
			out_q.param_count <= 5'd0;
		end else if (cmd.out_data) begin
			out_q.param_byte  <= rd_data;
			out_q.has_data    <= 1'b1;
			out_q.status      <= nrfc_pkg::ST_OK;
			out_q.last        <= stat.emit_last;
			out_q.param_count <= k_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== sv/nrfc_ctrl.sv =====
// nrfc_ctrl: state machine that walks the capture store one byte per cycle on an end item
// depends on nrfc_pkg; drives nrfc_datapath through ctrl_cmd_t; stalls on a held result
`default_nettype none

module nrfc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          in_op,
	output      logic                in_ready,
	input  wire nrfc_pkg::dp_stat_t  stat,
	output      nrfc_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_ACK    = 12'b0000_0000_0010,
		S_SRCH   = 12'b0000_0000_0100,
		S_LEN    = 12'b0000_0000_1000,
		S_LCS    = 12'b0000_0001_0000,
		S_TFI    = 12'b0000_0010_0000,
		S_RSP    = 12'b0000_0100_0000,
		S_DATA   = 12'b0000_1000_0000,
		S_DCS    = 12'b0001_0000_0000,
		S_POST   = 12'b0010_0000_0000,
		S_EMIT   = 12'b0100_0000_0000,
		S_REPORT = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == nrfc_pkg::OP_START) begin
						cmd.latch_start = 1'b1;
					end else if (in_op == nrfc_pkg::OP_BYTE) begin
						cmd.capture_wr = 1'b1;
					end else if (in_op == nrfc_pkg::OP_END) begin
						if (stat.short_cap) begin
							cmd.err_load = 1'b1;
							cmd.err_code = nrfc_pkg::ST_SHORT;
							state_d      = S_REPORT;
						end else begin
							cmd.ptr_op = nrfc_pkg::PTR_ZERO;
							state_d    = S_ACK;
						end
					end
				end
			end
			S_ACK: begin
				cmd.shift_win = 1'b1;
				if (!stat.ack_ok) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_BAD_ACK;
					state_d      = S_REPORT;
				end else begin
					cmd.ptr_op = nrfc_pkg::PTR_INC;
					if (stat.ack_last) begin
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (stat.ptr_end) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_NO_HDR;
					state_d      = S_REPORT;
				end else if (stat.hdr_hit) begin
					if (!stat.hdr_room) begin
						cmd.err_load = 1'b1;
						cmd.err_code = nrfc_pkg::ST_TRUNC;
						state_d      = S_REPORT;
					end else begin
						cmd.save_start = 1'b1;
						cmd.ptr_op     = nrfc_pkg::PTR_INC;
						state_d        = S_LEN;
					end
				end else begin
					cmd.shift_win = 1'b1;
					cmd.ptr_op    = nrfc_pkg::PTR_INC;
				end
			end
			S_LEN: begin
				cmd.load_len = 1'b1;
				cmd.ptr_op   = nrfc_pkg::PTR_INC;
				state_d      = S_LCS;
			end
			S_LCS: begin
				cmd.err_load = 1'b1;
				state_d      = S_REPORT;
				if (!stat.lcs_ok) begin
					cmd.err_code = nrfc_pkg::ST_LCS;
				end else if (!stat.len_ok) begin
					cmd.err_code = nrfc_pkg::ST_LEN_SMALL;
				end else if (!stat.frame_room) begin
					cmd.err_code = nrfc_pkg::ST_TRUNC;
				end else begin
					cmd.err_load = 1'b0;
					cmd.load_rem = 1'b1;
					cmd.ptr_op   = nrfc_pkg::PTR_INC;
					state_d      = S_TFI;
				end
			end
			S_TFI: begin
				if (!stat.tfi_ok) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_TFI;
					state_d      = S_REPORT;
				end else begin
					cmd.sum_first = 1'b1;
					cmd.ptr_op    = nrfc_pkg::PTR_INC;
					state_d       = S_RSP;
				end
			end
			S_RSP: begin
				if (!stat.rsp_ok) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_CMD;
					state_d      = S_REPORT;
				end else begin
					cmd.sum_add = 1'b1;
					cmd.ptr_op  = nrfc_pkg::PTR_INC;
					state_d     = stat.len_two ? S_DCS : S_DATA;
				end
			end
			S_DATA: begin
				cmd.sum_add = 1'b1;
				cmd.rem_dec = 1'b1;
				cmd.ptr_op  = nrfc_pkg::PTR_INC;
				if (stat.rem_one) begin
					state_d = S_DCS;
				end
			end
			S_DCS: begin
				if (!stat.dcs_ok) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_DCS;
					state_d      = S_REPORT;
				end else begin
					cmd.ptr_op = nrfc_pkg::PTR_INC;
					state_d    = S_POST;
				end
			end
			S_POST: begin
				if (!stat.post_ok) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_POSTAMBLE;
					state_d      = S_REPORT;
				end else if (stat.k_zero) begin
					cmd.err_load = 1'b1;
					cmd.err_code = nrfc_pkg::ST_OK;
					state_d      = S_REPORT;
				end else begin
					cmd.load_k = 1'b1;
					cmd.ptr_op = nrfc_pkg::PTR_FIRST;
					state_d    = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_data = 1'b1;
					cmd.ptr_op   = nrfc_pkg::PTR_INC;
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_REPORT: begin
				if (stat.out_free) begin
					cmd.out_err = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/nfc_response_frame_checker.sv =====
// nfc_response_frame_checker: top level, joins nrfc_ctrl and nrfc_datapath to the two channels
// depends on nrfc_pkg, nrfc_chan_if, nrfc_ctrl, nrfc_datapath, nrfc_ram
//
// channel  dir  payload               transfer
// item     in   nrfc_pkg::in_item_t   valid && ready
// result   out  nrfc_pkg::out_item_t  valid && ready
//
// start and byte items are taken without leaving idle; ready is high only while the block is idle
// an end item walks the store one byte per cycle through the single read port: the ack,
// the header search and the frame fields, stopping early when a check fails,
// then one row per parameter byte while the result is free, or one result row for an error or an empty result
// a held result does not block the next input; a stalled result holds the walk in place
// asynchronous reset clears counters, latched command and limit; the store is not cleared
`default_nettype none

module nfc_response_frame_checker #(
	parameter int CAPTURE_DEPTH = nrfc_pkg::CAPTURE_DEPTH
) (
	input wire logic   clk,
	input wire logic   arst_n,
	nrfc_chan_if.sink   item,
	nrfc_chan_if.source result
);

	nrfc_pkg::ctrl_cmd_t cmd;
	nrfc_pkg::dp_stat_t  stat;
	nrfc_pkg::in_item_t  in_data;
	nrfc_pkg::out_item_t out_data;
	logic                in_ready;
	logic                out_valid;

	assign in_data = item.data;

	nrfc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_op   (in_data.op),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	nrfc_datapath #(
		.CAPTURE_DEPTH(CAPTURE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.stat     (stat),
		.out_ready(result.ready),
		.out_valid(out_valid),
		.out_data (out_data)
	);

	assign item.ready   = in_ready;
	assign result.valid = out_valid;
	assign result.data  = out_data;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for nfc_response_frame_checker, predicts every result row
// drives ack plus response frames, broken frames and noise over the item channel
// depends on nrfc_pkg, nrfc_chan_if and the block's rtl
module tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [7:0] ACK_SEQ [nrfc_pkg::ACK_LEN] =
		'{8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
	localparam int IDLE_PCT = 36;
	localparam int PAUSE_CYCLES = 8;
	localparam int END_SLACK = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 180;

	typedef enum int {
		FR_GOOD, FR_SHORT, FR_BAD_ACK, FR_NO_HDR, FR_LCS, FR_LEN_SMALL, FR_TRUNC,
		FR_TFI, FR_CMD, FR_DCS, FR_POST, FR_OVERFLOW, FR_NOISE, FR_COUNT
	} frame_kind_t;

	typedef struct {
		nrfc_pkg::in_item_t it;
		bit                 drain;
	} pend_t;

	logic clk;
	logic arst_n;

	nrfc_chan_if #(.payload_t(nrfc_pkg::in_item_t))  item_ch ();
	nrfc_chan_if #(.payload_t(nrfc_pkg::out_item_t)) result_ch ();

	nfc_response_frame_checker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	pend_t               item_fifo [$];
	nrfc_pkg::out_item_t due_rows [$];
	logic [7:0]          cap_mem [nrfc_pkg::CAPTURE_DEPTH];
	int unsigned         cap_count;
	logic [7:0]          cur_cmd;
	logic [7:0]          cur_limit;
	int unsigned         n_sent;
	bit                  hold_off;
	int unsigned         pause_left;
	bit                  failed;
	int unsigned         cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic bit steady_phase();
		return n_sent >= 60 && n_sent < 140;
	endfunction

	function automatic nrfc_pkg::status_t frame_status(output int unsigned first,
			output int unsigned cnt);
		int unsigned n;
		int unsigned pos;
		int unsigned len;
		logic [7:0] lsum;
		logic [7:0] dsum;
		logic [7:0] rsp_want;
		first = 0;
		cnt = 0;
		n = cap_count;
		if (n < nrfc_pkg::ACK_LEN)
			return nrfc_pkg::ST_SHORT;
		for (int i = 0; i < nrfc_pkg::ACK_LEN; i++)
			if (cap_mem[i] != ACK_SEQ[i])
				return nrfc_pkg::ST_BAD_ACK;
		pos = nrfc_pkg::ACK_LEN;
		while (pos + 2 < n && !(cap_mem[pos] == nrfc_pkg::BYTE_ZERO &&
				cap_mem[pos + 1] == nrfc_pkg::BYTE_ZERO &&
				cap_mem[pos + 2] == nrfc_pkg::HDR_END))
			pos++;
		if (pos + 2 >= n)
			return nrfc_pkg::ST_NO_HDR;
		if (pos + 5 > n)
			return nrfc_pkg::ST_TRUNC;
		len = cap_mem[pos + 3];
		lsum = cap_mem[pos + 3] + cap_mem[pos + 4];
		if (lsum != nrfc_pkg::BYTE_ZERO)
			return nrfc_pkg::ST_LCS;
		if (len < 2)
			return nrfc_pkg::ST_LEN_SMALL;
		if (pos + len + nrfc_pkg::FRAME_EXTRA > n)
			return nrfc_pkg::ST_TRUNC;
		if (cap_mem[pos + 5] != nrfc_pkg::TFI_TO_HOST)
			return nrfc_pkg::ST_TFI;
		rsp_want = cur_cmd + 8'd1;
		if (cap_mem[pos + 6] != rsp_want)
			return nrfc_pkg::ST_CMD;
		dsum = '0;
		for (int unsigned i = 0; i <= len; i++)
			dsum += cap_mem[pos + 5 + i];
		if (dsum != nrfc_pkg::BYTE_ZERO)
			return nrfc_pkg::ST_DCS;
		if (cap_mem[pos + 6 + len] != nrfc_pkg::BYTE_ZERO)
			return nrfc_pkg::ST_POSTAMBLE;
		cnt = len - 2;
		if (cnt > cur_limit)
			cnt = cur_limit;
		if (cnt > nrfc_pkg::MAX_PARAMS)
			cnt = nrfc_pkg::MAX_PARAMS;
		first = pos + nrfc_pkg::PARAM_OFFSET;
		return nrfc_pkg::ST_OK;
	endfunction

	function automatic void apply_item(input nrfc_pkg::in_item_t it);
		nrfc_pkg::status_t st;
		int unsigned first;
		int unsigned cnt;
		nrfc_pkg::out_item_t row;
		case (it.op)
			nrfc_pkg::OP_START: begin
				cap_count = 0;
				cur_cmd = it.expected_cmd;
				cur_limit = it.param_limit;
			end
			nrfc_pkg::OP_BYTE: begin
				if (cap_count < nrfc_pkg::CAPTURE_DEPTH) begin
					cap_mem[cap_count] = it.rx_byte;
					cap_count++;
				end
			end
			nrfc_pkg::OP_END: begin
				st = frame_status(first, cnt);
				row = '0;
				row.status = st;
				row.last = 1'b1;
				if (st != nrfc_pkg::ST_OK || cnt == 0) begin
					due_rows.push_back(row);
				end else begin
					for (int unsigned i = 0; i < cnt; i++) begin
						row.param_byte = cap_mem[first + i];
						row.has_data = 1'b1;
						row.param_count = 5'(cnt);
						row.last = (i + 1 == cnt);
						due_rows.push_back(row);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic queue_item(input logic [1:0] op, input logic [7:0] b, input logic [7:0] cmd,
			input logic [7:0] lim);
		pend_t p;
		p.drain = 1'b0;
		p.it.op = op;
		p.it.rx_byte = b;
		p.it.expected_cmd = cmd;
		p.it.param_limit = lim;
		item_fifo.push_back(p);
	endtask

	task automatic queue_exchange(input frame_kind_t kind, input logic [7:0] cmd,
			input logic [7:0] lim, input int unsigned len, input int unsigned lead);
		logic [7:0] fb [$];
		logic [7:0] csum;
		int unsigned hdr;
		int unsigned keep;
		foreach (ACK_SEQ[i])
			fb.push_back(ACK_SEQ[i]);
		repeat (lead) fb.push_back(8'($urandom));
		hdr = fb.size();
		fb.push_back(nrfc_pkg::BYTE_ZERO);
		fb.push_back(nrfc_pkg::BYTE_ZERO);
		fb.push_back(nrfc_pkg::HDR_END);
		fb.push_back(8'(len));
		fb.push_back(8'(0 - len));
		fb.push_back(nrfc_pkg::TFI_TO_HOST);
		fb.push_back(cmd + 8'd1);
		repeat (len - 2) fb.push_back(8'($urandom));
		csum = '0;
		for (int unsigned i = 0; i < len; i++)
			csum += fb[hdr + 5 + i];
		fb.push_back(8'h00 - csum);
		fb.push_back(nrfc_pkg::BYTE_ZERO);
		case (kind)
			FR_SHORT: begin
				keep = $urandom_range(0, nrfc_pkg::ACK_LEN - 1);
				while (fb.size() > keep)
					void'(fb.pop_back());
			end
			FR_BAD_ACK: fb[$urandom_range(0, nrfc_pkg::ACK_LEN - 1)] ^=
				8'(1 << $urandom_range(0, 7));
			FR_NO_HDR: fb[hdr + 2] = 8'($urandom_range(0, 254));
			FR_LCS: fb[hdr + 4] += 8'($urandom_range(1, 255));
			FR_LEN_SMALL: begin
				fb[hdr + 3] = 8'($urandom_range(0, 1));
				fb[hdr + 4] = 8'h00 - fb[hdr + 3];
			end
			FR_TRUNC: begin
				keep = fb.size() - $urandom_range(1, fb.size() - hdr - 3);
				while (fb.size() > keep)
					void'(fb.pop_back());
			end
			FR_TFI: fb[hdr + 5] ^= 8'($urandom_range(1, 255));
			FR_CMD: fb[hdr + 6] ^= 8'($urandom_range(1, 255));
			FR_DCS: fb[hdr + 5 + len] ^= 8'($urandom_range(1, 255));
			FR_POST: fb[hdr + 6 + len] = 8'($urandom_range(1, 255));
			FR_OVERFLOW: repeat ($urandom_range(1, 14)) fb.push_back(8'($urandom));
			FR_NOISE: begin
				while (fb.size() > nrfc_pkg::ACK_LEN)
					void'(fb.pop_back());
				if ($urandom_range(0, 1))
					fb[0] = 8'($urandom);
				repeat ($urandom_range(0, 20)) fb.push_back(8'($urandom));
			end
			default: ;
		endcase
		queue_item(nrfc_pkg::OP_START, 8'($urandom), cmd, lim);
		foreach (fb[i]) begin
			if ($urandom_range(0, 24) == 0)
				queue_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
			queue_item(nrfc_pkg::OP_BYTE, fb[i], 8'($urandom), 8'($urandom));
		end
		queue_item(nrfc_pkg::OP_END, 8'($urandom), 8'($urandom), 8'($urandom));
		if ($urandom_range(0, 5) == 0)
			queue_item(nrfc_pkg::OP_END, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	always @(posedge clk or negedge arst_n) begin
		pend_t nxt;
		bit go;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
		end else begin
			go = 1'b0;
			nxt.it = '0;
			nxt.drain = 1'b0;
			if (item_ch.valid && item_ch.ready) begin
				apply_item(item_ch.data);
				n_sent++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (hold_off && due_rows.size() == 0) begin
					if (pause_left == 0)
						hold_off = 1'b0;
					else
						pause_left--;
				end
				if (!hold_off && item_fifo.size() != 0) begin
					if (item_fifo[0].drain) begin
						void'(item_fifo.pop_front());
						hold_off = 1'b1;
						pause_left = PAUSE_CYCLES;
					end else if (steady_phase() || $urandom_range(0, 99) >= IDLE_PCT) begin
						nxt = item_fifo.pop_front();
						go = 1'b1;
					end
				end
				item_ch.valid <= go;
				if (go)
					item_ch.data <= nxt.it;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		nrfc_pkg::out_item_t got;
		nrfc_pkg::out_item_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (due_rows.size() == 0) begin
					$error("result with no row due: %h", got);
					failed = 1'b1;
				end else begin
					want = due_rows.pop_front();
					if (got.param_byte !== want.param_byte) begin
						$error("param_byte expected %0h got %0h", want.param_byte, got.param_byte);
						failed = 1'b1;
					end
					if (got.has_data !== want.has_data) begin
						$error("has_data expected %0d got %0d", want.has_data, got.has_data);
						failed = 1'b1;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						failed = 1'b1;
					end
					if (got.last !== want.last) begin
						$error("last expected %0d got %0d", want.last, got.last);
						failed = 1'b1;
					end
					if (got.param_count !== want.param_count) begin
						$error("param_count expected %0d got %0d", want.param_count,
							got.param_count);
						failed = 1'b1;
					end
				end
			end
			result_ch.ready <= steady_phase() || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned xchg;
		int unsigned lead;
		int unsigned len;
		int unsigned pick;
		frame_kind_t kind;
		logic [7:0] lim;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		cap_count = 0;
		cur_cmd = '0;
		cur_limit = '0;
		n_sent = 0;
		hold_off = 1'b0;
		pause_left = 0;
		failed = 1'b0;
		cycles = 0;

		// end before any start, unused op code, capped and wrapped response, zero limit
		queue_item(nrfc_pkg::OP_END, 8'hFF, 8'hFF, 8'hFF);
		queue_item(OP_UNUSED, 8'h00, 8'h00, 8'h00);
		queue_exchange(FR_GOOD, 8'hFF, 8'hFF, 19, 0);
		queue_item(nrfc_pkg::OP_END, 8'h00, 8'h00, 8'h00);
		queue_exchange(FR_GOOD, 8'h00, 8'h00, 4, 0);
		queue_exchange(FR_OVERFLOW, 8'h7F, 8'd3, 6, 2);
		item_fifo.push_back('{it: '0, drain: 1'b1});

		xchg = 0;
		while (item_fifo.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				kind = FR_GOOD;
			else if (pick == 4)
				kind = FR_OVERFLOW;
			else if (pick == 5)
				kind = FR_NOISE;
			else
				kind = frame_kind_t'($urandom_range(FR_SHORT, FR_POST));
			lead = $urandom_range(0, 2);
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(2, 19 - lead);
			else
				len = $urandom_range(2, 5);
			case ($urandom_range(0, 3))
				0: lim = 8'h00;
				1: lim = 8'hFF;
				default: lim = 8'($urandom_range(0, 8));
			endcase
			queue_exchange(kind, 8'($urandom), lim, len, lead);
			if (xchg == 1)
				item_fifo.push_back('{it: '0, drain: 1'b1});
			xchg++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (item_fifo.size() != 0 || item_ch.valid || hold_off || due_rows.size() != 0)
			@(posedge clk);
		repeat (END_SLACK) @(posedge clk);
		if (!failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
sv/nrfc_pkg.sv
sv/nrfc_chan_if.sv
sv/nrfc_ram.sv
sv/nrfc_datapath.sv
sv/nrfc_ctrl.sv
sv/nfc_response_frame_checker.sv
tb/tb.sv
